// File: rtl/core/lcfd_pkg.sv
`timescale 1ns / 1ps

package lcfd_pkg;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int HDR_SUM = 255;

   // result kind codes
   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_HDR_ERR = 2'd2
   } kind_type;

   // parser phase, one-hot
   typedef enum logic [5:0] {
      PH_HUNT  = 6'b000001,
      PH_TYPE  = 6'b000010,
      PH_CODE  = 6'b000100,
      PH_LEN   = 6'b001000,
      PH_COMPL = 6'b010000,
      PH_DATA  = 6'b100000
   } phase_type;

   // one result beat as it moves from parser to output buffer
   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] frame_type;
      logic [BYTE_W-1:0] frame_code;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] byte_index;
      logic              last_of_frame;
   } rsp_type;

endpackage

// File: rtl/core/lcfd_parse.sv
`timescale 1ns / 1ps

module lcfd_parse
   import lcfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              item_vld,
   input  logic [BYTE_W-1:0] item_byte,
   input  logic              csr_vld,
   input  logic [BYTE_W-1:0] csr_byte,
   output logic              res_vld,
   output rsp_type           res
);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] preamble_ff;
   logic [BYTE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] code_ff, code_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W:0]   hdr_sum;
   logic [BYTE_W:0]   count_next;
   logic              is_last;

   assign hdr_sum    = {1'b0, len_ff} + {1'b0, item_byte};
   assign count_next = {1'b0, count_ff} + {{BYTE_W{1'b0}}, 1'b1};
   assign is_last    = (count_next == {1'b0, len_ff});

   // per-byte parse decision
   always_comb begin
      phase_in           = phase_ff;
      type_in            = type_ff;
      code_in            = code_ff;
      len_in             = len_ff;
      count_in           = count_ff;
      res_vld            = 1'b0;
      res.kind           = KIND_PAYLOAD;
      res.frame_type     = type_ff;
      res.frame_code     = code_ff;
      res.payload_byte   = '0;
      res.byte_index     = '0;
      res.last_of_frame  = 1'b0;
      unique case (phase_ff)
         PH_TYPE: begin
            type_in  = item_byte;
            phase_in = PH_CODE;
         end
         PH_CODE: begin
            code_in  = item_byte;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in   = item_byte;
            phase_in = PH_COMPL;
         end
         PH_COMPL: begin
            phase_in = PH_HUNT;
            if (hdr_sum != (BYTE_W+1)'(HDR_SUM)) begin
               res_vld  = 1'b1;
               res.kind = KIND_HDR_ERR;
            end else if (len_ff == '0) begin
               res_vld           = 1'b1;
               res.kind          = KIND_EMPTY;
               res.last_of_frame = 1'b1;
            end else begin
               count_in = '0;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            res_vld           = 1'b1;
            res.kind          = KIND_PAYLOAD;
            res.payload_byte  = item_byte;
            res.byte_index    = count_ff;
            res.last_of_frame = is_last;
            count_in          = count_next[BYTE_W-1:0];
            if (is_last) begin
               phase_in = PH_HUNT;
            end
         end
         default: begin
            phase_in = (item_byte == preamble_ff) ? PH_TYPE : PH_HUNT;
         end
      endcase
      if (!item_vld) begin
         res_vld = 1'b0;
      end
   end

   // parser state, moves only when a byte is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         type_ff  <= '0;
         code_ff  <= '0;
         len_ff   <= '0;
         count_ff <= '0;
      end else if (item_vld) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         code_ff  <= code_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

   // preamble register
   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= '0;
      end else if (csr_vld) begin
         preamble_ff <= csr_byte;
      end
   end

   // a header with a good check either ends the frame at once or enters payload
   a_compl_exit: assert property (@(posedge clock) disable iff (reset)
      (item_vld && phase_ff == PH_COMPL && !res_vld) |=> (phase_ff == PH_DATA))
      else $error("good header did not enter payload");

   // the index never runs past the frame length
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (count_ff < len_ff))
      else $error("payload index beyond frame length");

   // header errors never mark the end of a frame
   a_err_not_last: assert property (@(posedge clock) disable iff (reset)
      (res_vld && res.kind == KIND_HDR_ERR) |-> !res.last_of_frame)
      else $error("header error marked as last");

endmodule

// File: rtl/core/lcfd_skid.sv
`timescale 1ns / 1ps

module lcfd_skid
   import lcfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_vld,
   output logic    in_rdy,
   input  rsp_type in_data,
   output logic    out_vld,
   input  logic    out_rdy,
   output rsp_type out_data
);

   logic    main_vld_ff;
   logic    skid_vld_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    push;
   logic    main_free;

   assign in_rdy    = !skid_vld_ff;
   assign push      = in_vld && in_rdy;
   assign main_free = !main_vld_ff || out_rdy;
   assign out_vld   = main_vld_ff;
   assign out_data  = main_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (main_free) begin
         main_vld_ff <= skid_vld_ff || push;
         skid_vld_ff <= 1'b0;
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (main_free) begin
         main_ff <= skid_vld_ff ? skid_ff : in_data;
      end else if (push) begin
         skid_ff <= in_data;
      end
   end

   // the skid entry is only used behind a full main entry
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> main_vld_ff)
      else $error("skid entry without main entry");

   // the skid entry fills only while the output stalls
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(main_vld_ff && !out_rdy))
      else $error("skid filled without a stall");

endmodule

// File: rtl/core/length_checked_frame_deframer_core.sv
`timescale 1ns / 1ps

// Frame deframer for a received byte stream. Each req beat carries one byte;
// the core hunts for the preamble byte set through the csr channel, reads
// type, code, length and complement bytes, and emits a header-error beat if
// length plus complement is not 255, one empty-frame beat for a zero length,
// or one beat per payload byte tagged with type, code and index, with tlast
// on the final byte. It takes one byte every cycle while the output
// buffer has room; a byte passes the input register, one parse step and
// the output buffer, whose main register offers its result on rsp. The
// two-entry output buffer keeps the input side running while rsp is
// stalled, until both of its entries are full.
module length_checked_frame_deframer_core
   import lcfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] frame_type, [15:8] frame_code,
                                    // [23:16] payload_byte, [31:24] byte_index
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast,   // last_of_frame
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [7:0] preamble_value
);

   logic              in_vld_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              buf_rdy;
   logic              advance;
   logic              res_vld;
   rsp_type           res;
   rsp_type           out_data;

   assign csr_ready  = 1'b1;
   assign advance    = in_vld_ff && buf_rdy;
   assign req_tready = !in_vld_ff || buf_rdy;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   lcfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .item_vld  (advance),
      .item_byte (in_byte_ff),
      .csr_vld   (csr_valid),
      .csr_byte  (csr_data),
      .res_vld   (res_vld),
      .res       (res)
   );

   lcfd_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (res_vld),
      .in_rdy   (buf_rdy),
      .in_data  (res),
      .out_vld  (rsp_tvalid),
      .out_rdy  (rsp_tready),
      .out_data (out_data)
   );

   // output packing
   assign rsp_tdata = {out_data.byte_index, out_data.payload_byte,
                       out_data.frame_code, out_data.frame_type};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last_of_frame;

endmodule

// File: tb/tb_length_checked_frame_deframer_core.sv
`timescale 1ns / 1ps

module tb_length_checked_frame_deframer_core;
   import lcfd_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int SEGMENT_BYTES = 205;
   localparam int DIRECTED_ROWS = 23;

   // parser position as the predictor tracks it
   typedef enum logic [5:0] {
      ST_HUNT  = 6'b000001,
      ST_TYPE  = 6'b000010,
      ST_CODE  = 6'b000100,
      ST_LEN   = 6'b001000,
      ST_COMPL = 6'b010000,
      ST_DATA  = 6'b100000
   } parse_state_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] frame_type;
      logic [7:0] frame_code;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic       last_of_frame;
   } deframed_beat_type;

   // one directed byte; typed rows carry the beat they must produce
   typedef struct {
      logic [7:0] byte_value;
      bit         typed;
      kind_type   kind;
      logic [7:0] frame_type;
      logic [7:0] frame_code;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic       last_of_frame;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = 8'h00;

   int send_idle_pct = 16;
   int recv_idle_pct = 81;
   int fail_count    = 0;
   int sent_bytes    = 0;
   int stall_cycles  = 0;

   // predictor state
   parse_state_type pred_state    = ST_HUNT;
   logic [7:0]      pred_preamble = 8'h00;
   logic [7:0]      held_type     = 8'h00;
   logic [7:0]      held_code     = 8'h00;
   logic [7:0]      held_length   = 8'h00;
   logic [7:0]      rx_count      = 8'h00;

   deframed_beat_type expected_beats [$];

   // header checks, zero length, preamble inside header and payload
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'hFF, 1'b1, KIND_EMPTY,   8'hFF, 8'h00, 8'h00, 8'h00, 1'b1},
      '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h12, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h34, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h05, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h00, 1'b1, KIND_HDR_ERR, 8'h12, 8'h34, 8'h00, 8'h00, 1'b0},
      '{8'h77, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h5A, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'hA5, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h02, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'hFD, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h00, 1'b1, KIND_PAYLOAD, 8'h5A, 8'hA5, 8'h00, 8'h00, 1'b0},
      '{8'hFF, 1'b1, KIND_PAYLOAD, 8'h5A, 8'hA5, 8'hFF, 8'h01, 1'b1},
      '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'hFF, 1'b0, KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
      '{8'hFF, 1'b1, KIND_HDR_ERR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}
   };

   length_checked_frame_deframer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // advance the parser prediction by one received byte
   task automatic deframe_byte(input logic [7:0] b, output bit produced,
                               output deframed_beat_type beat);
      beat = '{KIND_PAYLOAD, held_type, held_code, 8'h00, 8'h00, 1'b0};
      produced = 1'b0;
      case (pred_state)
         ST_TYPE: begin
            held_type  = b;
            pred_state = ST_CODE;
         end
         ST_CODE: begin
            held_code  = b;
            pred_state = ST_LEN;
         end
         ST_LEN: begin
            held_length = b;
            pred_state  = ST_COMPL;
         end
         ST_COMPL: begin
            pred_state = ST_HUNT;
            if (int'(held_length) + int'(b) != HDR_SUM) begin
               produced  = 1'b1;
               beat.kind = KIND_HDR_ERR;
            end else if (held_length == 8'h00) begin
               produced           = 1'b1;
               beat.kind          = KIND_EMPTY;
               beat.last_of_frame = 1'b1;
            end else begin
               rx_count   = 8'h00;
               pred_state = ST_DATA;
            end
         end
         ST_DATA: begin
            produced           = 1'b1;
            beat.payload_byte  = b;
            beat.byte_index    = rx_count;
            beat.last_of_frame = (rx_count + 8'd1 == held_length);
            rx_count           = rx_count + 8'd1;
            if (beat.last_of_frame)
               pred_state = ST_HUNT;
         end
         default: begin
            pred_state = (b == pred_preamble) ? ST_TYPE : ST_HUNT;
         end
      endcase
   endtask

   // hold one byte on req until it is taken, with random gaps ahead of it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // send a byte and queue the beat it should produce
   task automatic feed_byte(input logic [7:0] b, input bit counts);
      bit                produced;
      deframed_beat_type beat;
      send_byte(b);
      deframe_byte(b, produced, beat);
      if (produced)
         expected_beats.push_back(beat);
      if (counts)
         sent_bytes++;
   endtask

   // let every queued beat come out and the pipeline settle
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_preamble(input logic [7:0] value);
      wait_drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid     <= 1'b0;
      pred_preamble = value;
   endtask

   // mostly well-formed frames, some broken headers, some line noise
   task automatic send_frame();
      int         pick;
      int         len;
      logic [7:0] compl_byte;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         repeat ($urandom_range(1, 4)) feed_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         len = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 8);
         feed_byte(pred_preamble, 1'b1);
         feed_byte(8'($urandom_range(0, 255)), 1'b1);
         feed_byte(8'($urandom_range(0, 255)), 1'b1);
         feed_byte(8'(len), 1'b1);
         compl_byte = 8'(HDR_SUM - len);
         if (pick < 27) begin
            compl_byte = 8'($urandom_range(0, 255));
            if (compl_byte == 8'(HDR_SUM - len))
               compl_byte = compl_byte ^ 8'h01;
         end
         feed_byte(compl_byte, 1'b1);
         if (pick >= 27) begin
            repeat (len) begin
               feed_byte(($urandom_range(0, 7) == 0) ? pred_preamble
                                                     : 8'($urandom_range(0, 255)), 1'b1);
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_value,
                              input logic [7:0] act_value);
      if (act_value !== exp_value) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_value, act_value);
         fail_count++;
      end
   endtask

   // compare one rsp beat with the oldest expectation
   task automatic check_beat();
      deframed_beat_type exp_beat;
      if (expected_beats.size() == 0) begin
         $error("rsp beat with nothing expected: tuser %0h tdata %h tlast %0b",
                rsp_tuser, rsp_tdata, rsp_tlast);
         fail_count++;
      end else begin
         exp_beat = expected_beats.pop_front();
         check_field("result_kind", 8'(exp_beat.kind), 8'(rsp_tuser));
         check_field("frame_type", exp_beat.frame_type, rsp_tdata[7:0]);
         check_field("frame_code", exp_beat.frame_code, rsp_tdata[15:8]);
         check_field("payload_byte", exp_beat.payload_byte, rsp_tdata[23:16]);
         check_field("byte_index", exp_beat.byte_index, rsp_tdata[31:24]);
         check_field("last_of_frame", 8'(exp_beat.last_of_frame), 8'(rsp_tlast));
      end
   endtask

   // receiver side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         check_beat();
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // watchdog on cycles with no beat moving on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("length_checked_frame_deframer_core verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      deframed_beat_type typed_beat;
      bit                produced;
      deframed_beat_type beat;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, preamble at its reset value
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_byte(directed_rows[i].byte_value);
         deframe_byte(directed_rows[i].byte_value, produced, beat);
         if (directed_rows[i].typed) begin
            typed_beat = '{directed_rows[i].kind, directed_rows[i].frame_type,
                           directed_rows[i].frame_code, directed_rows[i].payload_byte,
                           directed_rows[i].byte_index, directed_rows[i].last_of_frame};
            expected_beats.push_back(typed_beat);
         end else if (produced) begin
            expected_beats.push_back(beat);
         end
      end

      // random part: three idling modes, two preamble settings each
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 16;
               recv_idle_pct = 81;
            end
            1: begin
               send_idle_pct = 81;
               recv_idle_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 2; seg++) begin
            if (seg == 1)
               write_preamble(8'($urandom_range(0, 255)));
            else if (mode == 0)
               write_preamble(8'hFF);
            else if (mode == 1)
               write_preamble(8'h00);
            else
               write_preamble(8'h80);
            sent_bytes = 0;
            while (sent_bytes < SEGMENT_BYTES)
               send_frame();
         end
      end

      wait_drain();
      if (fail_count == 0)
         $display("length_checked_frame_deframer_core verification clean");
      else
         $display("length_checked_frame_deframer_core verification failed");
      $finish;
   end

endmodule
